FILE: hdl/sfxf_pkg.sv
// Package with shared types, codes and sizes for the serial FIFO with XON/XOFF flow control.
package sfxf_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 32;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);

  localparam logic [7:0] FLOW_XON  = 8'd17;
  localparam logic [7:0] FLOW_XOFF = 8'd19;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] CFG_FLOW_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_RX_HIGH_MARK = 2'd1;
  localparam logic [1:0] CFG_RX_LOW_MARK  = 2'd2;

  typedef enum logic [2:0] {
    ACT_LINE_IN  = 3'd0,
    ACT_HOST_RD  = 3'd1,
    ACT_HOST_WR  = 3'd2,
    ACT_TX_SLOT  = 3'd3,
    ACT_FLUSH_RX = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic       keep;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [7:0] line_data;
    logic       line_valid;
    logic [6:0] rx_fill;
    logic [4:0] tx_fill;
    logic [7:0] dropped_total;
    logic [6:0] peak_fill;
  } out_item_t;

endpackage

FILE: hdl/sfxf_ram.sv
// Generic single-port-write, registered-read RAM used for the ring FIFO storage.
module sfxf_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/serial_fifo_xon_xoff_flow_control.sv
// Top level of the serial byte buffer: receive and transmit ring FIFOs with XON/XOFF control.
//
//   Channel  | Direction | Handshake                  | Payload
//   ---------+-----------+----------------------------+-------------------------------
//   in       | input     | in_valid / in_ready        | in_data  (action, data, keep)
//   out      | output    | out_valid / out_ready      | out_data (status, bytes, fills)
//   cfg      | input     | cfg_we (no wait)           | cfg_index, cfg_data
//
// Line byte in, host write, flush, a refused or empty action and a flow character on a
// transmit slot form their result at the transfer, and that result is registered.
// A host read of a byte, or a transmit slot that sends a buffered byte, waits for the
// registered read of the FIFO memory and is loaded from the read data in the read state;
// no new item is taken in that state. A new item is taken only when the output register is
// empty or its result transfers in the same cycle, so a stalled result holds off the input.
// Reset clears pointers, flow state, counters, config and out_valid; memories are not cleared.
module serial_fifo_xon_xoff_flow_control
  import sfxf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  // Configuration registers.
  logic       flow_enable;
  logic [6:0] rx_high_mark;
  logic [6:0] rx_low_mark;

  // Pointer and flow state. The rings hold at most depth-1 bytes, so the fill is the
  // pointer difference taken modulo the depth, which is the natural wrap of the width.
  state_t              state, state_next;
  logic [RX_PTR_W-1:0] rx_head, rx_head_next;
  logic [RX_PTR_W-1:0] rx_tail, rx_tail_next;
  logic [TX_PTR_W-1:0] tx_head, tx_head_next;
  logic [TX_PTR_W-1:0] tx_tail, tx_tail_next;
  logic                flow_is_xoff, flow_is_xoff_next;
  logic                flow_sent, flow_sent_next;
  logic [7:0]          drop_counter, drop_counter_next;
  logic [6:0]          peak_level, peak_level_next;

  // Result of an item whose byte still comes from a memory read.
  out_item_t pend, pend_next;
  logic      pend_rx, pend_rx_next;
  logic      pend_rx_state;
  out_item_t read_result;

  out_item_t result;
  logic      accept;
  logic      load_direct;
  logic      needs_read;

  logic                rx_we, rx_re, tx_we, tx_re;
  logic [7:0]          rx_rdata, tx_rdata;
  logic [RX_PTR_W-1:0] rx_head_inc, rx_tail_inc, rx_fill_new;
  logic [TX_PTR_W-1:0] tx_head_inc, tx_tail_inc;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign rx_head_inc = rx_head + 1'b1;
  assign rx_tail_inc = rx_tail + 1'b1;
  assign tx_head_inc = tx_head + 1'b1;
  assign tx_tail_inc = tx_tail + 1'b1;

  sfxf_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (in_data.data),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  sfxf_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (in_data.data),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  // Next state of the pointers and flow control, and the result of the accepted item.
  // Reads and writes of the memories only happen at a transfer, and the state that
  // waits for read data takes no item, so the same entry is never written and read
  // in overlapping cycles.
  always_comb begin
    state_next        = state;
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    flow_is_xoff_next = flow_is_xoff;
    flow_sent_next    = flow_sent;
    drop_counter_next = drop_counter;
    peak_level_next   = peak_level;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    needs_read        = 1'b0;
    pend_rx           = 1'b0;
    rx_fill_new       = '0;
    result            = '0;

    if (accept) begin
      case (action_t'(in_data.action))
        ACT_LINE_IN: begin
          if (rx_head_inc != rx_tail) begin
            rx_we        = 1'b1;
            rx_head_next = rx_head_inc;
          end else begin
            result.status = STAT_FULL;
            if (drop_counter == 8'hFF) begin
              drop_counter_next = 8'd1;
            end else begin
              drop_counter_next = drop_counter + 8'd1;
            end
          end
          rx_fill_new = rx_head_next - rx_tail;
          if (7'(rx_fill_new) > peak_level) begin
            peak_level_next = 7'(rx_fill_new);
          end
          if (flow_enable && !flow_is_xoff && (7'(rx_fill_new) >= rx_high_mark)) begin
            flow_is_xoff_next = 1'b1;
            flow_sent_next    = 1'b0;
          end
        end
        ACT_HOST_RD: begin
          if (rx_head == rx_tail) begin
            result.status = STAT_EMPTY;
          end else begin
            rx_re      = 1'b1;
            needs_read = 1'b1;
            pend_rx    = 1'b1;
            if (!in_data.keep) begin
              rx_tail_next = rx_tail_inc;
              rx_fill_new  = rx_head - rx_tail_inc;
              if (flow_enable && flow_is_xoff && (7'(rx_fill_new) < rx_low_mark)) begin
                flow_is_xoff_next = 1'b0;
                flow_sent_next    = 1'b0;
              end
            end
          end
        end
        ACT_HOST_WR: begin
          if (tx_head_inc == tx_tail) begin
            result.status = STAT_FULL;
          end else begin
            tx_we        = 1'b1;
            tx_head_next = tx_head_inc;
          end
        end
        ACT_TX_SLOT: begin
          if (!flow_sent) begin
            result.line_data  = flow_is_xoff ? FLOW_XOFF : FLOW_XON;
            result.line_valid = 1'b1;
            flow_sent_next    = 1'b1;
          end else if (tx_head != tx_tail) begin
            tx_re             = 1'b1;
            needs_read        = 1'b1;
            result.line_valid = 1'b1;
            tx_tail_next      = tx_tail_inc;
          end
        end
        ACT_FLUSH_RX: begin
          rx_head_next = rx_tail;
          if (flow_enable && flow_is_xoff) begin
            flow_is_xoff_next = 1'b0;
            flow_sent_next    = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (needs_read) begin
        state_next = ST_READ;
      end
    end else if (state == ST_READ) begin
      state_next = ST_IDLE;
    end

    result.rx_fill       = 7'(RX_PTR_W'(rx_head_next - rx_tail_next));
    result.tx_fill       = 5'(TX_PTR_W'(tx_head_next - tx_tail_next));
    result.dropped_total = drop_counter_next;
    result.peak_fill     = peak_level_next;
  end

  assign load_direct  = accept && !needs_read;
  assign pend_next    = needs_read ? result : pend;
  assign pend_rx_next = needs_read ? pend_rx : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_enable  <= 1'b1;
      rx_high_mark <= 7'd16;
      rx_low_mark  <= 7'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLOW_ENABLE:  flow_enable  <= cfg_data[0];
        CFG_RX_HIGH_MARK: rx_high_mark <= cfg_data;
        CFG_RX_LOW_MARK:  rx_low_mark  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      flow_is_xoff <= 1'b0;
      flow_sent    <= 1'b1;
      drop_counter <= '0;
      peak_level   <= '0;
    end else begin
      state        <= state_next;
      rx_head      <= rx_head_next;
      rx_tail      <= rx_tail_next;
      tx_head      <= tx_head_next;
      tx_tail      <= tx_tail_next;
      flow_is_xoff <= flow_is_xoff_next;
      flow_sent    <= flow_sent_next;
      drop_counter <= drop_counter_next;
      peak_level   <= peak_level_next;
    end
  end

  // The pending result is registered alongside the memory read and waits for its byte.
  always_ff @(posedge clk) begin
    pend          <= pend_next;
    pend_rx_state <= pend_rx_next;
  end

  // The byte from the memory goes into the read field or the line field of the result.
  always_comb begin
    read_result = pend;
    if (pend_rx_state) begin
      read_result.read_data = rx_rdata;
    end else begin
      read_result.line_data = tx_rdata;
    end
  end

  // Output register: loaded at a transfer that needs no memory read, or when read data returns.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || (state == ST_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_data <= result;
    end else if (state == ST_READ) begin
      out_data <= read_result;
    end
  end

endmodule

FILE: hdl/sfxf_checker.sv
// Port-level checker for the serial FIFO block, bound to the top level.
module sfxf_checker
  import sfxf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting result holds until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Every transfer in gives a result at once or blocks the input while memory is read.
  a_in_progress: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("accepted item produced no result and did not stall input");

  // The receive fill only rises on line bytes, which also update the peak.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.peak_fill >= out_data.rx_fill)
    else $error("peak fill below current receive fill");

  // An empty read reports an empty receive FIFO and no byte.
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_EMPTY) |->
      (out_data.rx_fill == 7'd0) && (out_data.read_data == 8'd0))
    else $error("empty status with nonempty FIFO or data");

  // No line byte is reported without the line valid flag.
  a_line_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.line_valid |-> out_data.line_data == 8'd0)
    else $error("line data without line valid");

endmodule

bind serial_fifo_xon_xoff_flow_control sfxf_checker u_sfxf_checker (.*);
